@@ hdl/rtcm3_pkg.sv @@
`default_nettype none

package rtcm3_pkg;

    localparam logic [7:0]  PREAMBLE = 8'hD3;
    localparam logic [23:0] CRC_POLY = 24'h864CFB;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 10;
    localparam int CRC_W  = 24;

    // Output sequencer phase: three header bytes, the body byte, three CRC bytes.
    typedef enum logic [6:0] {
        PH_HDR0 = 7'b000_0001,
        PH_HDR1 = 7'b000_0010,
        PH_HDR2 = 7'b000_0100,
        PH_BODY = 7'b000_1000,
        PH_CRC0 = 7'b001_0000,
        PH_CRC1 = 7'b010_0000,
        PH_CRC2 = 7'b100_0000
    } t_phase;

    typedef struct packed {
        logic update;   // fold the byte into the CRC
        logic clear;    // start from zero before folding
    } t_crc_ctl;

    // One byte of CRC-24Q, most significant bit first.
    function automatic logic [CRC_W-1:0] crc24q_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [DATA_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 16'h0000};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rtcm3_frame_crc24q_builder_core.sv @@
// RTCM 3 frame builder with CRC-24Q.
// Slave channel: one message body byte per item. tdata[7:0] is the body byte,
// tdata[17:8] the body length, which is read only on the first byte of a
// frame (a length of zero is taken as one).
// Master channel: one frame byte per item in tdata[7:0]; tlast marks the last
// CRC byte of each frame.
// Each accepted body byte yields one output byte; the first byte of a frame
// adds three header bytes ahead of it, and the last adds three CRC bytes.
// An accepted item is held in one input register and sequenced out through
// one output register at one byte per cycle while the receiver is ready, so
// a body byte passes through both registers. Body bytes flow at one item per
// cycle unless the receiver stalls; tready stays low while the header and CRC
// bytes go out. Besides receiver stalls, the output sequencer is the only limit.
// Reset (synchronous, active low) clears the frame state, the CRC and the valid
// flags of both registers; the block then waits for the first byte of a new frame.
// When the receiver stalls, the output byte holds, the input register fills,
// and tready drops until the output register moves again.
`default_nettype none

module rtcm3_frame_crc24q_builder_core
    import rtcm3_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [7:0] data_byte, [17:8] payload_length
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic             o_m_tlast    // frame_last
);

    // Frame state, updated as items are accepted.
    logic             r_in_frame;
    logic [LEN_W-1:0] r_bytes_seen;
    logic [LEN_W-1:0] r_frame_len;

    // Held item.
    logic              r_hold_valid;
    logic [DATA_W-1:0] r_hold_data;
    logic [LEN_W-1:0]  r_hold_len;
    logic              r_hold_end;
    t_phase            r_phase;

    // Output register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              w_out_free;
    logic              w_move;
    logic              w_item_done;
    logic              w_accept;
    logic [LEN_W-1:0]  w_len_in;
    logic [LEN_W-1:0]  w_eff_len;
    logic [LEN_W-1:0]  w_seen_next;
    logic              w_is_end;
    logic [DATA_W-1:0] w_emit_byte;
    t_phase            n_phase;
    t_crc_ctl          w_crc_ctl;
    logic [CRC_W-1:0]  w_crc;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_move      = r_hold_valid && w_out_free;
    assign w_item_done = w_move && (((r_phase == PH_BODY) && !r_hold_end) ||
                                    (r_phase == PH_CRC2));
    assign o_s_tready  = !r_hold_valid || w_item_done;
    assign w_accept    = i_s_tvalid && o_s_tready;

    assign w_len_in    = i_s_tdata[DATA_W +: LEN_W];
    assign w_eff_len   = r_in_frame ? r_frame_len :
                         ((w_len_in == '0) ? LEN_W'(1) : w_len_in);
    assign w_seen_next = (r_in_frame ? r_bytes_seen : '0) + LEN_W'(1);
    assign w_is_end    = (w_seen_next == w_eff_len);

    always_comb begin
        w_emit_byte = r_hold_data;
        n_phase     = r_phase;
        w_crc_ctl   = '{update: 1'b0, clear: 1'b0};
        unique case (r_phase)
            PH_HDR0: begin
                w_emit_byte = PREAMBLE;
                n_phase     = PH_HDR1;
                w_crc_ctl   = '{update: w_move, clear: 1'b1};
            end
            PH_HDR1: begin
                w_emit_byte = {6'b00_0000, r_hold_len[LEN_W-1:8]};
                n_phase     = PH_HDR2;
                w_crc_ctl   = '{update: w_move, clear: 1'b0};
            end
            PH_HDR2: begin
                w_emit_byte = r_hold_len[7:0];
                n_phase     = PH_BODY;
                w_crc_ctl   = '{update: w_move, clear: 1'b0};
            end
            PH_BODY: begin
                w_emit_byte = r_hold_data;
                n_phase     = PH_CRC0;
                w_crc_ctl   = '{update: w_move, clear: 1'b0};
            end
            PH_CRC0: begin
                w_emit_byte = w_crc[23:16];
                n_phase     = PH_CRC1;
            end
            PH_CRC1: begin
                w_emit_byte = w_crc[15:8];
                n_phase     = PH_CRC2;
            end
            PH_CRC2: begin
                w_emit_byte = w_crc[7:0];
                n_phase     = PH_CRC2;
            end
            default: begin
                w_emit_byte = r_hold_data;
                n_phase     = PH_BODY;
            end
        endcase
    end

    rtcm3_crc24q u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .i_byte  (w_emit_byte),
        .o_crc   (w_crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_seen <= '0;
            r_frame_len  <= '0;
            r_hold_valid <= 1'b0;
            r_phase      <= PH_BODY;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_frame   <= !w_is_end;
                r_bytes_seen <= w_is_end ? '0 : w_seen_next;
                r_frame_len  <= w_eff_len;
                r_hold_valid <= 1'b1;
                r_phase      <= r_in_frame ? PH_BODY : PH_HDR0;
            end else begin
                if (w_item_done) begin
                    r_hold_valid <= 1'b0;
                end
                if (w_move) begin
                    r_phase <= n_phase;
                end
            end

            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hold_data <= i_s_tdata[DATA_W-1:0];
            r_hold_len  <= w_eff_len;
            r_hold_end  <= w_is_end;
        end
        if (w_move) begin
            r_out_byte <= w_emit_byte;
            r_out_last <= (r_phase == PH_CRC2);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ hdl/rtcm3_crc24q.sv @@
`default_nettype none

module rtcm3_crc24q
    import rtcm3_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_crc_ctl          i_ctl,
    input  wire logic [DATA_W-1:0] i_byte,
    output logic      [CRC_W-1:0]  o_crc
);

    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.update) begin
            n_crc = crc24q_byte(i_ctl.clear ? '0 : r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

@@ hdl/rtcm3_checker.sv @@
`default_nettype none

module rtcm3_checker
    import rtcm3_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata,
    input wire logic        o_m_tlast
);

    // High while the next item on the master side must open a frame.
    logic r_frame_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b1;
        end else if (o_m_tvalid && i_m_tready) begin
            r_frame_open <= o_m_tlast;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("master item changed while stalled");

    a_preamble_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_frame_open |-> (o_m_tdata == PREAMBLE) && !o_m_tlast)
        else $error("frame does not open with the preamble");

    a_no_double_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast |=> !(o_m_tvalid && o_m_tlast))
        else $error("two frame ends in a row");

    a_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind rtcm3_frame_crc24q_builder_core rtcm3_checker u_rtcm3_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

@@ tb/rtcm3_frame_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the frame builder, predicts every frame byte that
// an accepted body byte must cause and compares the master side against it.
module rtcm3_frame_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [7:0] data_byte, [17:8] payload_length
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [7:0]  i_m_tdata,   // [7:0] out_byte
    input  wire logic        i_m_tlast,   // frame_last
    output int               o_fail_count,
    output int               o_bytes_due
);

    localparam logic [7:0]  SYNC_BYTE   = 8'hD3;
    localparam logic [23:0] CRC24Q_POLY = 24'h864CFB;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_last;
    } t_frame_byte;

    t_frame_byte frame_bytes_due[$];

    logic        open_frame;
    logic [9:0]  body_count;
    logic [9:0]  frame_len;
    logic [23:0] running_crc;

    // CRC-24Q, one data bit at a time, most significant bit first.
    function automatic logic [23:0] crc24q_fold(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[23] ^ b[i];
            c  = {c[22:0], 1'b0};
            if (fb) begin
                c = c ^ CRC24Q_POLY;
            end
        end
        return c;
    endfunction

    task automatic fold_and_queue(input logic [7:0] b);
        running_crc = crc24q_fold(running_crc, b);
        frame_bytes_due.push_back('{out_byte: b, frame_last: 1'b0});
    endtask

    task automatic predict_frame_bytes(input logic [7:0] body, input logic [9:0] len_field);
        logic [9:0] len;
        if (!open_frame) begin
            // A zero length at frame start is treated as a one byte body.
            len         = (len_field == 10'd0) ? 10'd1 : len_field;
            frame_len   = len;
            body_count  = 10'd0;
            running_crc = 24'd0;
            open_frame  = 1'b1;
            fold_and_queue(SYNC_BYTE);
            fold_and_queue({6'b000000, len[9:8]});
            fold_and_queue(len[7:0]);
        end
        fold_and_queue(body);
        body_count = body_count + 10'd1;
        if (body_count == frame_len) begin
            frame_bytes_due.push_back('{out_byte: running_crc[23:16], frame_last: 1'b0});
            frame_bytes_due.push_back('{out_byte: running_crc[15:8],  frame_last: 1'b0});
            frame_bytes_due.push_back('{out_byte: running_crc[7:0],   frame_last: 1'b1});
            open_frame = 1'b0;
            body_count = 10'd0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_byte want;
        if (!i_rst_n) begin
            open_frame   = 1'b0;
            body_count   = 10'd0;
            frame_len    = 10'd0;
            running_crc  = 24'd0;
            o_fail_count = 0;
            frame_bytes_due.delete();
        end else begin
            // Results are registered and never appear in the cycle their item is accepted, so the pop goes first.
            if (i_m_tvalid && i_m_tready) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("unexpected frame item: out_byte 0x%02h, frame_last %0b",
                           i_m_tdata, i_m_tlast);
                    o_fail_count++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (i_m_tdata !== want.out_byte) begin
                        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                               want.out_byte, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== want.frame_last) begin
                        $error("frame_last mismatch: expected %0b, actual %0b",
                               want.frame_last, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_frame_bytes(i_s_tdata[7:0], i_s_tdata[17:8]);
            end
        end
        o_bytes_due = frame_bytes_due.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RAND_ITEMS      = 320;
    localparam int QUIET_ITEMS     = 40;
    localparam int LONG_BODY       = 300;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = 24'd0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int fail_count;
    int bytes_due;
    int idle_cycles = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    bit quiet_tail  = 1'b0;

    always #5 clk = ~clk;

    rtcm3_frame_crc24q_builder_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    rtcm3_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_bytes_due  (bytes_due)
    );

    // Ends the run when neither channel moves an item for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: bursts of ready and stall, one long hold-off on request, and
    // always ready in the quiet tail.
    initial begin : receiver
        int run_len;
        wait (rst_n);
        forever begin
            if (holds_done < holds_asked) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                holds_done++;
            end else if (quiet_tail) begin
                m_tready <= 1'b1;
                @(posedge clk);
            end else begin
                run_len = $urandom_range(1, 30);
                m_tready <= 1'b1;
                repeat (run_len) @(posedge clk);
                if ($urandom_range(0, 1) == 0) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
        end
    end

    function automatic logic [7:0] pick_body_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic [9:0] len, input int gap_pct);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b000000, len, d};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Only the first item of a frame carries a meaningful length; the rest
    // carry random values that the block must ignore.
    task automatic send_frame(input logic [9:0] hdr_len, input int gap_pct);
        int body_len;
        body_len = (hdr_len == 10'd0) ? 1 : int'(hdr_len);
        for (int i = 0; i < body_len; i++) begin
            send_byte(pick_body_byte(), (i == 0) ? hdr_len : 10'($urandom_range(0, 1023)),
                      gap_pct);
        end
    endtask

    initial begin : stimulus
        int       rand_items;
        int       frame_idx;
        int       r;
        int       gap_pct;
        logic [9:0] len;
        rand_items = 0;
        frame_idx  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frames, the zero length case and body byte extremes.
        send_byte(8'h00, 10'd1, 30);
        send_byte(8'hFF, 10'd0, 30);
        // A seven byte frame; the lengths given after its first byte are
        // ignored, extremes included.
        send_byte(8'hA5, 10'd7, 30);
        send_byte(8'h5A, 10'd1023, 30);
        send_byte(8'h80, 10'd0, 30);
        send_byte(8'h01, 10'h155, 0);
        send_byte(8'hFE, 10'h2AA, 0);
        send_byte(8'h7F, 10'd2, 0);
        send_byte(8'h00, 10'd1023, 0);

        // Let the block drain completely before the random part.
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (bytes_due == 0);
        @(posedge clk);

        while (rand_items < RAND_ITEMS) begin
            if (rand_items >= RAND_ITEMS - QUIET_ITEMS) begin
                quiet_tail = 1'b1;
            end
            if (rand_items >= 60 && holds_asked == 0) begin
                holds_asked = 1;
            end
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
            if (frame_idx == 8) begin
                // One long frame sets a high length bit.
                send_frame(10'(LONG_BODY), gap_pct);
                rand_items += LONG_BODY;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    len = 10'd0;
                end else if (r < 70) begin
                    len = 10'($urandom_range(1, 6));
                end else if (r < 95) begin
                    len = 10'($urandom_range(7, 24));
                end else begin
                    len = 10'($urandom_range(25, 120));
                end
                send_frame(len, gap_pct);
                rand_items += (len == 10'd0) ? 1 : int'(len);
            end
            frame_idx++;
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        wait (bytes_due == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rtcm3_pkg.sv
hdl/rtcm3_crc24q.sv
hdl/rtcm3_frame_crc24q_builder_core.sv
hdl/rtcm3_checker.sv
tb/rtcm3_frame_checker.sv
tb/tb_top.sv
